// ===== rtl/core/crug_pkg.sv =====
`timescale 1ns / 1ps

package crug_pkg;

  localparam int CHALLENGE_BYTES = 8;
  localparam int CHAR_W          = 8;
  localparam int HALF_W          = CHALLENGE_BYTES * 4;
  localparam int TEXT_W          = CHALLENGE_BYTES * CHAR_W;
  localparam int AGE_W           = 17;
  localparam int DATA_W          = 32;
  localparam int ADDR_W          = 3;

  localparam logic [AGE_W-1:0] AGE_MAX        = {AGE_W{1'b1}};
  localparam logic [AGE_W-1:0] CHAL_TO_RESET  = 17'd60000;
  localparam logic [AGE_W-1:0] UNLK_TO_RESET  = 17'd120000;
  localparam logic [7:0]       CONFIRM_LEN    = 8'(CHALLENGE_BYTES * 2);

  localparam logic OR_CHAL_TO = 1'b0;
  localparam logic OR_UNLK_TO = 1'b1;

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_LOCK    = 3'd1;
  localparam logic [2:0] OP_REQUEST = 3'd2;
  localparam logic [2:0] OP_CONFIRM = 3'd3;
  localparam logic [2:0] OP_QUERY   = 3'd4;

  localparam logic [2:0] ST_LOCKED   = 3'd0;
  localparam logic [2:0] ST_ISSUED   = 3'd1;
  localparam logic [2:0] ST_RND_FAIL = 3'd2;
  localparam logic [2:0] ST_EXPIRED  = 3'd3;
  localparam logic [2:0] ST_INVALID  = 3'd4;
  localparam logic [2:0] ST_UNLOCKED = 3'd5;
  localparam logic [2:0] ST_INFO     = 3'd6;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [TEXT_W-1:0] random_value;
    logic              random_ok;
    logic [TEXT_W-1:0] confirm_text_high;
    logic [TEXT_W-1:0] confirm_text_low;
    logic [7:0]        confirm_length;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              authorized;
    logic [TEXT_W-1:0] challenge_text_high;
    logic [TEXT_W-1:0] challenge_text_low;
  } out_word_t;

  typedef struct packed {
    logic [AGE_W-1:0] chal_timeout;
    logic [AGE_W-1:0] unlk_timeout;
  } timeouts_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h57 + {4'd0, nib};
    end
    return c;
  endfunction

  // First character lands in the top byte.
  function automatic logic [TEXT_W-1:0] hex_half(input logic [HALF_W-1:0] half);
    logic [TEXT_W-1:0] text;
    text = '0;
    for (int i = 0; i < CHALLENGE_BYTES; i++) begin
      text[i*CHAR_W +: CHAR_W] = hex_char(half[i*4 +: 4]);
    end
    return text;
  endfunction

endpackage

// ===== rtl/core/crug_cfg.sv =====
`timescale 1ns / 1ps

module crug_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [crug_pkg::ADDR_W-1:0]  paddr,
  input  logic [crug_pkg::DATA_W-1:0]  pwdata,
  output logic [crug_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output crug_pkg::timeouts_t          timeouts
);

  logic [crug_pkg::AGE_W-1:0] chal_to_r, chal_to_nxt;
  logic [crug_pkg::AGE_W-1:0] unlk_to_r, unlk_to_nxt;
  logic                       wr_en;
  logic                       reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  always_comb begin
    chal_to_nxt = chal_to_r;
    unlk_to_nxt = unlk_to_r;
    if (wr_en) begin
      if (reg_sel == crug_pkg::OR_CHAL_TO) begin
        chal_to_nxt = pwdata[crug_pkg::AGE_W-1:0];
      end else begin
        unlk_to_nxt = pwdata[crug_pkg::AGE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chal_to_r <= crug_pkg::CHAL_TO_RESET;
      unlk_to_r <= crug_pkg::UNLK_TO_RESET;
    end else begin
      chal_to_r <= chal_to_nxt;
      unlk_to_r <= unlk_to_nxt;
    end
  end

  always_comb begin
    if (reg_sel == crug_pkg::OR_CHAL_TO) begin
      prdata = {{(crug_pkg::DATA_W - crug_pkg::AGE_W){1'b0}}, chal_to_r};
    end else begin
      prdata = {{(crug_pkg::DATA_W - crug_pkg::AGE_W){1'b0}}, unlk_to_r};
    end
  end

  assign timeouts.chal_timeout = chal_to_r;
  assign timeouts.unlk_timeout = unlk_to_r;

endmodule

// ===== rtl/core/crug_eval.sv =====
`timescale 1ns / 1ps

module crug_eval (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  crug_pkg::in_word_t   item,
  input  crug_pkg::timeouts_t  timeouts,
  output crug_pkg::out_word_t  result
);

  logic [crug_pkg::TEXT_W-1:0] chal_val_r, chal_val_nxt;
  logic [crug_pkg::AGE_W-1:0]  chal_age_r, chal_age_nxt;
  logic [crug_pkg::AGE_W-1:0]  sess_age_r, sess_age_nxt;
  logic                        waiting_r, waiting_nxt;
  logic                        open_r, open_nxt;
  logic [crug_pkg::TEXT_W-1:0] rnd_hi_txt, rnd_lo_txt;
  logic [crug_pkg::TEXT_W-1:0] chal_hi_txt, chal_lo_txt;
  logic                        mismatch;
  logic [2:0]                  status;
  logic [crug_pkg::TEXT_W-1:0] txt_hi, txt_lo;

  assign rnd_hi_txt  = crug_pkg::hex_half(item.random_value[2*crug_pkg::HALF_W-1:crug_pkg::HALF_W]);
  assign rnd_lo_txt  = crug_pkg::hex_half(item.random_value[crug_pkg::HALF_W-1:0]);
  assign chal_hi_txt = crug_pkg::hex_half(chal_val_r[2*crug_pkg::HALF_W-1:crug_pkg::HALF_W]);
  assign chal_lo_txt = crug_pkg::hex_half(chal_val_r[crug_pkg::HALF_W-1:0]);

  assign mismatch = (item.confirm_length != crug_pkg::CONFIRM_LEN) ||
                    (item.confirm_text_high != chal_hi_txt) ||
                    (item.confirm_text_low != chal_lo_txt);

  always_comb begin
    chal_val_nxt = chal_val_r;
    chal_age_nxt = chal_age_r;
    sess_age_nxt = sess_age_r;
    waiting_nxt  = waiting_r;
    open_nxt     = open_r;
    status       = crug_pkg::ST_INFO;
    txt_hi       = '0;
    txt_lo       = '0;
    case (item.opcode)
      crug_pkg::OP_TICK: begin
        if (chal_age_r != crug_pkg::AGE_MAX) begin
          chal_age_nxt = chal_age_r + 1'b1;
        end
        if (sess_age_r != crug_pkg::AGE_MAX) begin
          sess_age_nxt = sess_age_r + 1'b1;
        end
      end
      crug_pkg::OP_LOCK: begin
        chal_val_nxt = '0;
        chal_age_nxt = '0;
        sess_age_nxt = '0;
        waiting_nxt  = 1'b0;
        open_nxt     = 1'b0;
        status       = crug_pkg::ST_LOCKED;
      end
      crug_pkg::OP_REQUEST: begin
        chal_age_nxt = '0;
        sess_age_nxt = '0;
        open_nxt     = 1'b0;
        if (item.random_ok) begin
          chal_val_nxt = item.random_value;
          waiting_nxt  = 1'b1;
          txt_hi       = rnd_hi_txt;
          txt_lo       = rnd_lo_txt;
          status       = crug_pkg::ST_ISSUED;
        end else begin
          chal_val_nxt = '0;
          waiting_nxt  = 1'b0;
          status       = crug_pkg::ST_RND_FAIL;
        end
      end
      crug_pkg::OP_CONFIRM: begin
        if (!waiting_r || (chal_age_r >= timeouts.chal_timeout) || mismatch) begin
          chal_val_nxt = '0;
          chal_age_nxt = '0;
          sess_age_nxt = '0;
          waiting_nxt  = 1'b0;
          open_nxt     = 1'b0;
          if (!waiting_r || (chal_age_r >= timeouts.chal_timeout)) begin
            status = crug_pkg::ST_EXPIRED;
          end else begin
            status = crug_pkg::ST_INVALID;
          end
        end else begin
          chal_val_nxt = '0;
          waiting_nxt  = 1'b0;
          open_nxt     = 1'b1;
          sess_age_nxt = '0;
          status       = crug_pkg::ST_UNLOCKED;
        end
      end
      crug_pkg::OP_QUERY: begin
        if (open_r && (sess_age_r >= timeouts.unlk_timeout)) begin
          chal_val_nxt = '0;
          chal_age_nxt = '0;
          sess_age_nxt = '0;
          waiting_nxt  = 1'b0;
          open_nxt     = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chal_val_r <= '0;
      chal_age_r <= '0;
      sess_age_r <= '0;
      waiting_r  <= 1'b0;
      open_r     <= 1'b0;
    end else if (adv) begin
      chal_val_r <= chal_val_nxt;
      chal_age_r <= chal_age_nxt;
      sess_age_r <= sess_age_nxt;
      waiting_r  <= waiting_nxt;
      open_r     <= open_nxt;
    end
  end

  assign result.status              = status;
  assign result.authorized          = open_nxt;
  assign result.challenge_text_high = txt_hi;
  assign result.challenge_text_low  = txt_lo;

`ifndef SYNTHESIS
  // A pending challenge and an open session never coexist.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(waiting_r && open_r))
    else $error("challenge pending while session open");

  // The stored challenge is zero whenever none is pending.
  a_val_clr: assert property (@(posedge clk) disable iff (!rst_n)
    !waiting_r |-> (chal_val_r == '0))
    else $error("stale challenge value");

  // A successful confirm always leaves a fresh session age.
  a_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && result.status == crug_pkg::ST_UNLOCKED) |=> (sess_age_r == '0) && open_r)
    else $error("session not opened fresh");
`endif

endmodule

// ===== rtl/core/challenge_response_unlock_gate.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Word
// in_       input      in_valid / in_stall    crug_pkg::in_word_t
// out_      output     out_valid / out_stall  crug_pkg::out_word_t
// cfg_      input      APB write, pready = 1  two 17-bit timeout registers
//
// One word per cycle unless out_ stalls; each word passes the input and then the output register.
// The input register feeds one stage of decode and compare logic that updates
// the state and loads the output register. Reset clears all state and loads
// the default timeouts. A stalled output holds; the input register still takes
// a word while the output register waits, and in_stall rises only when both hold.

module challenge_response_unlock_gate (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  crug_pkg::in_word_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output crug_pkg::out_word_t          out_data,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [crug_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [crug_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [crug_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                         cfg_pready
);

  crug_pkg::in_word_t   stg_r;
  logic                 stg_vld_r, stg_vld_nxt;
  crug_pkg::out_word_t  out_r;
  logic                 out_vld_r, out_vld_nxt;
  crug_pkg::out_word_t  result;
  crug_pkg::timeouts_t  timeouts;
  logic                 out_free;
  logic                 adv;
  logic                 in_take;

  assign out_free = !out_vld_r || !out_stall;
  assign adv      = stg_vld_r && out_free;
  assign in_stall = stg_vld_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  crug_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .pready   (cfg_pready),
    .timeouts (timeouts)
  );

  crug_eval u_eval (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .item     (stg_r),
    .timeouts (timeouts),
    .result   (result)
  );

  always_comb begin
    stg_vld_nxt = stg_vld_r;
    if (in_take) begin
      stg_vld_nxt = 1'b1;
    end else if (adv) begin
      stg_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_r <= in_data;
    end
    if (adv) begin
      out_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // Challenge text is only ever shown with an issued challenge.
  a_txt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.status != crug_pkg::ST_ISSUED) |->
      (out_r.challenge_text_high == '0) && (out_r.challenge_text_low == '0))
    else $error("challenge text outside an issued challenge");

  // Issuing a challenge always closes the session.
  a_issue_lock: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.status == crug_pkg::ST_ISSUED) |-> !out_r.authorized)
    else $error("session open with a new challenge");

  // A word held in the input register is never dropped while the output waits.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_vld_r && !out_free) |=> stg_vld_r && $stable(stg_r))
    else $error("staged word lost under stall");
`endif

endmodule

// ===== bench/tb_challenge_response_unlock_gate.sv =====
`timescale 1ns / 1ps

module tb_challenge_response_unlock_gate;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int RANDOM_WORDS = 1350;
  localparam int RANDOM_PHASES = 8;

  class unlock_scoreboard;
    logic [crug_pkg::AGE_W-1:0]  chal_to;
    logic [crug_pkg::AGE_W-1:0]  unlk_to;
    logic [crug_pkg::TEXT_W-1:0] chal_val;
    logic [crug_pkg::AGE_W-1:0]  chal_age;
    logic [crug_pkg::AGE_W-1:0]  sess_age;
    bit                          chal_wait;
    bit                          sess_open;
    crug_pkg::out_word_t         expected_q[$];
    int                          errors;
    int                          checked;
    int                          status_seen[8];

    function new();
      chal_to = crug_pkg::CHAL_TO_RESET;
      unlk_to = crug_pkg::UNLK_TO_RESET;
      wipe_state();
      errors = 0;
      checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void wipe_state();
      chal_val = '0;
      chal_age = '0;
      sess_age = '0;
      chal_wait = 0;
      sess_open = 0;
    endfunction

    static function logic [crug_pkg::TEXT_W-1:0] hex_text(
        logic [crug_pkg::HALF_W-1:0] half);
      logic [crug_pkg::TEXT_W-1:0] t;
      logic [3:0]                  nib;
      logic [7:0]                  ch;
      t = '0;
      for (int i = 7; i >= 0; i--) begin
        nib = half[i*4 +: 4];
        if (nib < 4'd10) begin
          ch = 8'h30 + {4'd0, nib};
        end else begin
          ch = 8'h61 + {4'd0, nib} - 8'd10;
        end
        t = {t[crug_pkg::TEXT_W-9:0], ch};
      end
      return t;
    endfunction

    function void set_timeout(logic idx, logic [crug_pkg::AGE_W-1:0] v);
      if (idx == crug_pkg::OR_CHAL_TO) begin
        chal_to = v;
      end else begin
        unlk_to = v;
      end
    endfunction

    function void note_input(crug_pkg::in_word_t w);
      crug_pkg::out_word_t e;
      e = '0;
      e.status = crug_pkg::ST_INFO;
      case (w.opcode)
        crug_pkg::OP_TICK: begin
          if (chal_age < crug_pkg::AGE_MAX) chal_age++;
          if (sess_age < crug_pkg::AGE_MAX) sess_age++;
        end
        crug_pkg::OP_LOCK: begin
          wipe_state();
          e.status = crug_pkg::ST_LOCKED;
        end
        crug_pkg::OP_REQUEST: begin
          wipe_state();
          if (!w.random_ok) begin
            e.status = crug_pkg::ST_RND_FAIL;
          end else begin
            chal_val = w.random_value;
            chal_wait = 1;
            e.challenge_text_high = hex_text(w.random_value[63:32]);
            e.challenge_text_low = hex_text(w.random_value[31:0]);
            e.status = crug_pkg::ST_ISSUED;
          end
        end
        crug_pkg::OP_CONFIRM: begin
          if (!chal_wait || chal_age >= chal_to) begin
            wipe_state();
            e.status = crug_pkg::ST_EXPIRED;
          end else if (w.confirm_length != crug_pkg::CONFIRM_LEN ||
                       w.confirm_text_high != hex_text(chal_val[63:32]) ||
                       w.confirm_text_low != hex_text(chal_val[31:0])) begin
            wipe_state();
            e.status = crug_pkg::ST_INVALID;
          end else begin
            chal_val = '0;
            chal_wait = 0;
            sess_open = 1;
            sess_age = '0;
            e.status = crug_pkg::ST_UNLOCKED;
          end
        end
        crug_pkg::OP_QUERY: begin
          if (sess_open && sess_age >= unlk_to) wipe_state();
        end
        default: begin
        end
      endcase
      e.authorized = sess_open;
      expected_q.push_back(e);
    endfunction

    function void check_result(crug_pkg::out_word_t got);
      crug_pkg::out_word_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result word: status %0d", got.status);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      status_seen[got.status]++;
      if (got.status !== e.status) begin
        $error("status expected %0d actual %0d", e.status, got.status);
        errors++;
      end
      if (got.authorized !== e.authorized) begin
        $error("authorized expected %0d actual %0d", e.authorized, got.authorized);
        errors++;
      end
      if (got.challenge_text_high !== e.challenge_text_high) begin
        $error("challenge_text_high expected %h actual %h",
               e.challenge_text_high, got.challenge_text_high);
        errors++;
      end
      if (got.challenge_text_low !== e.challenge_text_low) begin
        $error("challenge_text_low expected %h actual %h",
               e.challenge_text_low, got.challenge_text_low);
        errors++;
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  crug_pkg::in_word_t          in_data = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  crug_pkg::out_word_t         out_data;
  logic                        cfg_psel = 1'b0;
  logic                        cfg_penable = 1'b0;
  logic                        cfg_pwrite = 1'b0;
  logic [crug_pkg::ADDR_W-1:0] cfg_paddr = '0;
  logic [crug_pkg::DATA_W-1:0] cfg_pwdata = '0;
  logic [crug_pkg::DATA_W-1:0] cfg_prdata;
  logic                        cfg_pready;

  unlock_scoreboard sb = new();
  int  cycles = 0;
  bit  gaps_on = 1;
  bit  stall_on = 1;
  int  burst_left = 0;
  int  settings_used = 0;
  int  stall_cnt = 0;
  int  stall_mode = 0;

  challenge_response_unlock_gate i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    stall_cnt++;
    if (stall_cnt % 64 == 0) stall_mode = $urandom_range(0, 3);
    if (!stall_on) begin
      out_stall <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (stall_cnt % 8 >= 5);
      endcase
    end
  end

  function automatic crug_pkg::in_word_t word_of(logic [2:0] op);
    crug_pkg::in_word_t w;
    w.opcode = op;
    w.random_value = {$urandom, $urandom};
    w.random_ok = 1'($urandom_range(0, 1));
    w.confirm_text_high = {$urandom, $urandom};
    w.confirm_text_low = {$urandom, $urandom};
    w.confirm_length = 8'($urandom_range(0, 255));
    return w;
  endfunction

  function automatic crug_pkg::in_word_t request_of(logic [crug_pkg::TEXT_W-1:0] v,
                                                    logic ok);
    crug_pkg::in_word_t w;
    w = word_of(crug_pkg::OP_REQUEST);
    w.random_value = v;
    w.random_ok = ok;
    return w;
  endfunction

  function automatic crug_pkg::in_word_t confirm_of(logic [crug_pkg::TEXT_W-1:0] v);
    crug_pkg::in_word_t w;
    w = word_of(crug_pkg::OP_CONFIRM);
    w.confirm_text_high = unlock_scoreboard::hex_text(v[63:32]);
    w.confirm_text_low = unlock_scoreboard::hex_text(v[31:0]);
    w.confirm_length = crug_pkg::CONFIRM_LEN;
    return w;
  endfunction

  function automatic int tick_span(logic [crug_pkg::AGE_W-1:0] t);
    return (t > 17'd30) ? 30 : int'(t) + 2;
  endfunction

  task automatic put_word(crug_pkg::in_word_t w);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    sb.note_input(w);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_timeout(logic idx, logic [crug_pkg::AGE_W-1:0] v);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= crug_pkg::ADDR_W'({idx, 2'b00});
    cfg_pwdata <= crug_pkg::DATA_W'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_timeout(idx, v);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic set_timeouts(logic [crug_pkg::AGE_W-1:0] chal,
                              logic [crug_pkg::AGE_W-1:0] unlk);
    settle();
    write_timeout(crug_pkg::OR_CHAL_TO, chal);
    write_timeout(crug_pkg::OR_UNLK_TO, unlk);
    settings_used++;
  endtask

  task automatic run_random(int target);
    int                          done;
    int                          k;
    logic [crug_pkg::TEXT_W-1:0] v;
    crug_pkg::in_word_t          w;
    done = 0;
    while (done < target) begin
      if ($urandom_range(0, 99) < 70) begin
        v = {$urandom, $urandom};
        put_word(request_of(v, ($urandom_range(0, 9) != 0)));
        done++;
        k = $urandom_range(0, tick_span(sb.chal_to));
        repeat (k) begin
          put_word(word_of(crug_pkg::OP_TICK));
          done++;
        end
        w = confirm_of(v);
        case ($urandom_range(0, 7))
          0: w.confirm_length ^= 8'(1 << $urandom_range(0, 7));
          1: w.confirm_text_high[$urandom_range(0, 63)] ^= 1'b1;
          2: w.confirm_text_low[$urandom_range(0, 63)] ^= 1'b1;
          default: begin
          end
        endcase
        put_word(w);
        done++;
        repeat ($urandom_range(0, 4)) begin
          repeat ($urandom_range(0, tick_span(sb.unlk_to) / 2)) begin
            put_word(word_of(crug_pkg::OP_TICK));
            done++;
          end
          put_word(word_of(crug_pkg::OP_QUERY));
          done++;
        end
        if ($urandom_range(0, 3) == 0) begin
          put_word(word_of(crug_pkg::OP_LOCK));
          done++;
        end
      end else begin
        put_word(word_of(3'($urandom_range(0, 7))));
        done++;
      end
      if ($urandom_range(0, 99) == 0) settle();
    end
  endtask

  initial begin
    crug_pkg::in_word_t          w;
    logic [crug_pkg::TEXT_W-1:0] v;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset timeouts.
    put_word(word_of(crug_pkg::OP_QUERY));
    put_word(word_of(crug_pkg::OP_TICK));
    put_word(word_of(crug_pkg::OP_CONFIRM));
    put_word(request_of('1, 1'b0));
    put_word(request_of('1, 1'b1));
    put_word(confirm_of('1));
    put_word(word_of(crug_pkg::OP_QUERY));
    put_word(request_of('0, 1'b1));
    w = confirm_of('0);
    w.confirm_length = 8'hff;
    put_word(w);
    v = 64'h0123456789abcdef;
    put_word(request_of(v, 1'b1));
    w = confirm_of(v);
    w.confirm_text_low[7:0] = 8'h65;
    put_word(w);
    v = 64'hfedcba9876543210;
    put_word(request_of(v, 1'b1));
    w = confirm_of(v);
    w.confirm_length = 8'h00;
    put_word(w);
    put_word(word_of(crug_pkg::OP_LOCK));
    for (int op = crug_pkg::OP_QUERY + 1; op < 8; op++) put_word(word_of(3'(op)));
    w = word_of(crug_pkg::OP_CONFIRM);
    w.confirm_text_high = '1;
    w.confirm_text_low = '1;
    w.confirm_length = crug_pkg::CONFIRM_LEN;
    put_word(w);

    // A zero challenge timeout expires a challenge at once.
    set_timeouts(17'd0, 17'd5);
    v = {$urandom, $urandom};
    put_word(request_of(v, 1'b1));
    put_word(confirm_of(v));

    // A zero unlock timeout closes the session at the first query.
    set_timeouts(17'd2, 17'd0);
    put_word(request_of(v, 1'b1));
    put_word(confirm_of(v));
    put_word(word_of(crug_pkg::OP_TICK));
    put_word(word_of(crug_pkg::OP_QUERY));

    // Stale session flag until a query, and challenge expiry by ticks.
    set_timeouts(17'd2, 17'd2);
    put_word(request_of(v, 1'b1));
    put_word(word_of(crug_pkg::OP_TICK));
    put_word(confirm_of(v));
    repeat (3) put_word(word_of(crug_pkg::OP_TICK));
    put_word(word_of(crug_pkg::OP_QUERY));
    put_word(request_of(v, 1'b1));
    repeat (2) put_word(word_of(crug_pkg::OP_TICK));
    put_word(confirm_of(v));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: set_timeouts(17'd1, 17'd1);
        1: set_timeouts(crug_pkg::AGE_MAX, crug_pkg::AGE_MAX);
        2: set_timeouts(17'd1, crug_pkg::AGE_MAX);
        default: set_timeouts(17'($urandom_range(1, 40)), 17'($urandom_range(1, 40)));
      endcase
      run_random(RANDOM_WORDS / RANDOM_PHASES);
    end

    settle();
    repeat (10) @(posedge clk);
    $display("%0d result words checked over %0d timeout settings.",
             sb.checked, settings_used);
    $display({"Status mix: locked %0d, issued %0d, random failed %0d, ",
              "expired %0d, invalid %0d, unlocked %0d, info %0d."},
             sb.status_seen[crug_pkg::ST_LOCKED], sb.status_seen[crug_pkg::ST_ISSUED],
             sb.status_seen[crug_pkg::ST_RND_FAIL], sb.status_seen[crug_pkg::ST_EXPIRED],
             sb.status_seen[crug_pkg::ST_INVALID], sb.status_seen[crug_pkg::ST_UNLOCKED],
             sb.status_seen[crug_pkg::ST_INFO]);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
